/* rtl/core/bed_pkg.sv */
// Shared constants and types for the backslash escape decoder.
`default_nettype none
package bed_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  // At most four result bytes come out of one input byte.
  localparam int unsigned GRP_BYTES = 4;
  localparam int unsigned GRP_IDX_W = $clog2(GRP_BYTES);

  // Queue of result groups between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register map: word index taken from paddr[2].
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_CONVERT_CTRL = 1'b0;

  // Result bytes of one input byte.
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [GRP_IDX_W-1:0]      cnt_m1;
    logic                      last;
    logic                      any;
  } grp_t;

  typedef struct packed {
    logic en;
    grp_t grp;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* rtl/core/bed_front.sv */
// Front end: accepts input bytes, tracks escapes and builds result groups.
`default_nettype none
module bed_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_string,
  input  wire logic               convert_ctrl,
  input  wire bed_pkg::q_status_t q_status,
  output bed_pkg::push_t          push
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BS   = 4'b0010,
    ST_ONE  = 4'b0100,
    ST_TWO  = 4'b1000
  } esc_state_t;

  esc_state_t state, state_next;
  logic [7:0] held0, held1, held0_next, held1_next;
  logic       changed, changed_next;

  logic [bed_pkg::GRP_BYTES-1:0][7:0] res;
  logic [bed_pkg::GRP_IDX_W:0]        n;
  logic                               accept;
  logic                               is_bs, is_quote, is_digit;
  logic [7:0]                         d0, d1, d2, octal;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  assign is_bs    = (data_byte == bed_pkg::CH_BACKSLASH);
  assign is_quote = (data_byte == bed_pkg::CH_QUOTE);
  assign is_digit = data_byte inside {[bed_pkg::CH_ZERO:bed_pkg::CH_NINE]};

  // (d0*64 + d1*8 + d2) mod 256
  assign d0    = held0 - bed_pkg::CH_ZERO;
  assign d1    = held1 - bed_pkg::CH_ZERO;
  assign d2    = data_byte - bed_pkg::CH_ZERO;
  assign octal = {d0[1:0], 6'b0} + {d1[4:0], 3'b0} + d2;

  always_comb begin
    res          = '0;
    n            = '0;
    state_next   = state;
    held0_next   = held0;
    held1_next   = held1;
    changed_next = changed;
    case (state)
      ST_IDLE: begin
        if (is_bs) begin
          state_next = ST_BS;
        end else begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = data_byte;
          n = n + 1'b1;
        end
      end
      ST_BS: begin
        if (is_bs || is_quote) begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = data_byte;
          n            = n + 1'b1;
          changed_next = 1'b1;
          state_next   = ST_IDLE;
        end else if (convert_ctrl && is_digit) begin
          held0_next = data_byte;
          state_next = ST_ONE;
        end else begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = bed_pkg::CH_BACKSLASH;
          n = n + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ONE: begin
        if (is_digit) begin
          held1_next = data_byte;
          state_next = ST_TWO;
        end else begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = bed_pkg::CH_BACKSLASH;
          n = n + 1'b1;
          res[n[bed_pkg::GRP_IDX_W-1:0]] = held0;
          n = n + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TWO: begin
        if (is_digit) begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = octal;
          n            = n + 1'b1;
          changed_next = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          res[n[bed_pkg::GRP_IDX_W-1:0]] = bed_pkg::CH_BACKSLASH;
          n = n + 1'b1;
          res[n[bed_pkg::GRP_IDX_W-1:0]] = held0;
          n = n + 1'b1;
          res[n[bed_pkg::GRP_IDX_W-1:0]] = held1;
          n = n + 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Broken escape: the new byte is taken as if nothing were pending.
    if (state != ST_IDLE && state_next == ST_IDLE && !is_bs
        && !(state == ST_BS && is_quote)
        && !(state == ST_TWO && is_digit)) begin
      res[n[bed_pkg::GRP_IDX_W-1:0]] = data_byte;
      n = n + 1'b1;
    end else if (state != ST_IDLE && state_next == ST_IDLE && is_bs && state != ST_BS) begin
      state_next = ST_BS;
    end else if (state == ST_BS && state_next == ST_IDLE && is_quote) begin
      state_next = ST_IDLE;
    end

    // End of string: flush whatever is still held.
    if (end_of_string) begin
      if (state_next != ST_IDLE) begin
        res[n[bed_pkg::GRP_IDX_W-1:0]] = bed_pkg::CH_BACKSLASH;
        n = n + 1'b1;
      end
      if (state_next == ST_ONE || state_next == ST_TWO) begin
        res[n[bed_pkg::GRP_IDX_W-1:0]] = held0_next;
        n = n + 1'b1;
      end
      if (state_next == ST_TWO) begin
        res[n[bed_pkg::GRP_IDX_W-1:0]] = held1_next;
        n = n + 1'b1;
      end
    end
  end

  always_comb begin
    push.en         = accept && (n != '0);
    push.grp.bytes  = res;
    push.grp.cnt_m1 = bed_pkg::GRP_IDX_W'(n - 1'b1);
    push.grp.last   = end_of_string;
    push.grp.any    = end_of_string && changed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      changed <= 1'b0;
    end else if (accept) begin
      state   <= end_of_string ? ST_IDLE : state_next;
      changed <= end_of_string ? 1'b0 : changed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bed_queue.sv */
// Short queue of result groups between the front and back ends.
`default_nettype none
module bed_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bed_pkg::push_t push,
  input  wire logic           pop,
  output bed_pkg::grp_t       head,
  output bed_pkg::q_status_t  status
);

  bed_pkg::grp_t                   mem [bed_pkg::Q_DEPTH];
  logic [bed_pkg::Q_PTR_W-1:0]     wptr, rptr;
  logic [bed_pkg::Q_CNT_W-1:0]     count;
  logic                            do_pop;

  assign status.full  = (count == bed_pkg::Q_CNT_W'(bed_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rptr];
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.en) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push.en, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      mem[wptr] <= push.grp;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bed_back.sv */
// Back end: walks each result group and presents one byte per transfer.
`default_nettype none
module bed_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bed_pkg::grp_t      head,
  input  wire bed_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output logic                    any_unescaped
);

  logic [bed_pkg::GRP_IDX_W-1:0] idx;
  logic                          grp_end;
  logic                          xfer;

  assign out_valid     = !q_status.empty;
  assign grp_end       = (idx == head.cnt_m1);
  assign out_byte      = head.bytes[idx];
  assign out_last      = head.last && grp_end;
  assign any_unescaped = head.any && grp_end;
  assign xfer          = out_valid && !out_stall;
  assign pop           = xfer && grp_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= grp_end ? '0 : idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/backslash_escape_decoder.sv */
// Top level of the backslash escape decoder: APB register, front, queue, back.
// Each input transfer's result group is registered in the queue before its bytes are offered.
// Throughput: one input byte per cycle while each yields at most one result and
// the output is not stalled; a byte that yields k results (up to 4) takes k output transfers.
// A four-group queue absorbs bursts; input stalls only when it is full.
// Reset (synchronous): no escape pending, queue empty, convert_ctrl = 1.
`default_nettype none
module backslash_escape_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bed_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        end_of_string,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  output logic                             any_unescaped
);

  logic               convert_ctrl;
  bed_pkg::push_t     push;
  bed_pkg::grp_t      head;
  bed_pkg::q_status_t q_status;
  logic               pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bed_pkg::REG_CONVERT_CTRL) ? {31'b0, convert_ctrl} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      convert_ctrl <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bed_pkg::REG_CONVERT_CTRL) begin
      convert_ctrl <= pwdata[0];
    end
  end

  bed_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .convert_ctrl  (convert_ctrl),
    .q_status      (q_status),
    .push          (push)
  );

  bed_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  bed_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .any_unescaped (any_unescaped)
  );

  // The escape flag only rides on the final byte of a string.
  a_any_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && any_unescaped |-> out_last)
    else $error("any_unescaped without out_last");

  // A full queue means results are waiting at the output.
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

  // End of string always yields a result on the next cycle.
  a_eos_yields: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_string |=> out_valid)
    else $error("end of string produced no result");

endmodule
`default_nettype wire
